// ===== rtl/twpg_pkg.sv =====
// ----------------------------------------------------------------------------
// twpg_pkg
// Shared types and constants for the time-window progress grader.
// ----------------------------------------------------------------------------
package twpg_pkg;

    // Ring geometry.
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    // Field widths.
    localparam int TIME_W = 32;
    localparam int PROG_W = 24;
    localparam int CNTD_W = PROG_W - 1;
    localparam int SUM_W  = 31;
    localparam int CNT_W  = 7;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_HORIZON = 2'd0;
    localparam logic [1:0] REG_COMPLY  = 2'd1;
    localparam logic [1:0] REG_VIOLATE = 2'd2;

    localparam logic [TIME_W-1:0] HORIZON_RST = 32'd1000;
    localparam logic [SUM_W-1:0]  COMPLY_RST  = 31'd1000;
    localparam logic [SUM_W-1:0]  VIOLATE_RST = 31'd3000;

    // Grade codes.
    localparam logic [1:0] GRADE_COMPLIANT = 2'd0;
    localparam logic [1:0] GRADE_MINOR     = 2'd1;
    localparam logic [1:0] GRADE_MAJOR     = 2'd2;

    typedef struct packed {
        logic                     first_of_run;
        logic [TIME_W-1:0]        sample_time_ms;
        logic signed [PROG_W-1:0] progress_mm;
        logic                     in_oncoming;
        logic                     at_intersection;
    } t_twpg_in;

    typedef struct packed {
        logic [SUM_W-1:0]  max_sum_mm;
        logic [TIME_W-1:0] worst_start_ms;
        logic [TIME_W-1:0] worst_end_ms;
        logic [CNT_W-1:0]  worst_count;
        logic [1:0]        grade;
        logic              window_clipped;
    } t_twpg_out;

    // Control from the sequencer to the accumulate unit.
    typedef struct packed {
        logic clear;
        logic acc_en;
    } t_twpg_acc_ctl;

endpackage

// ===== rtl/twpg_ring.sv =====
// ----------------------------------------------------------------------------
// twpg_ring
// Sample ring: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module twpg_ring (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [twpg_pkg::RING_AW-1:0]   i_waddr,
    input  logic [twpg_pkg::TIME_W-1:0]    i_wtime,
    input  logic [twpg_pkg::CNTD_W-1:0]    i_wcounted,
    input  logic [twpg_pkg::RING_AW-1:0]   i_raddr,
    output logic [twpg_pkg::TIME_W-1:0]    o_rtime,
    output logic [twpg_pkg::CNTD_W-1:0]    o_rcounted
);
    import twpg_pkg::*;

    logic [TIME_W+CNTD_W-1:0] r_mem [RING_DEPTH];
    logic [TIME_W+CNTD_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wtime, i_wcounted};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rtime    = r_rd[TIME_W+CNTD_W-1:CNTD_W];
    assign o_rcounted = r_rd[CNTD_W-1:0];

endmodule

// ===== rtl/twpg_accum.sv =====
// ----------------------------------------------------------------------------
// twpg_accum
// Shared horizon compare and window accumulate unit, one ring entry a cycle.
// ----------------------------------------------------------------------------
module twpg_accum (
    input  logic                          i_clk,
    input  twpg_pkg::t_twpg_acc_ctl       i_ctl,
    input  logic [twpg_pkg::TIME_W-1:0]   i_t_new,
    input  logic [twpg_pkg::TIME_W-1:0]   i_horizon,
    input  logic [twpg_pkg::TIME_W-1:0]   i_t_old,
    input  logic [twpg_pkg::CNTD_W-1:0]   i_counted,
    output logic                          o_hit,
    output logic [twpg_pkg::SUM_W-1:0]    o_sum,
    output logic [twpg_pkg::CNT_W-1:0]    o_cnt,
    output logic [twpg_pkg::TIME_W-1:0]   o_start
);
    import twpg_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] diff;
    logic [SUM_W:0]    wide_sum;

    // A stored sample at or after the new one always counts as in horizon.
    assign diff  = i_t_new - i_t_old;
    assign o_hit = (i_t_old >= i_t_new) || (diff <= i_horizon);

    assign wide_sum = {1'b0, r_sum} + {{(SUM_W + 1 - CNTD_W){1'b0}}, i_counted};

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_start <= i_t_new;
        end else if (i_ctl.acc_en && o_hit) begin
            r_sum <= wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
            if (r_cnt != CNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_t_old < r_start) begin
                r_start <= i_t_old;
            end
        end
    end

    assign o_sum   = r_sum;
    assign o_cnt   = r_cnt;
    assign o_start = r_start;

endmodule

// ===== rtl/time_window_progress_grader_core.sv =====
// ----------------------------------------------------------------------------
// time_window_progress_grader_core
// Sums counted progress over a look-back time window of recent samples and
// grades the largest window sum of the run.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  -----------------------
//  in        input      i_in_valid / o_in_stall    i_in_item  (t_twpg_in)
//  out       output     o_out_valid / i_out_stall  o_out_item (t_twpg_out)
//  config    input      APB psel/penable/pready    paddr, pwdata, prdata
//
//  A result is ready once the sequencer has walked all fill stored samples,
//  where fill is the number of stored samples after this one is written (1 to
//  64). The core is idle again at that same edge, so the next sample can go in
//  in the cycle after it. The walk over the ring, one entry per cycle through
//  the single read port, sets how long each sample takes.
//  Reset is synchronous and active low; it clears the run state and loads
//  the register defaults. The ring needs no clearing pass: the fill count
//  masks entries not yet written. While an item is in work o_in_stall is
//  high. A finished item waits in the output register while the next one is
//  worked; if it is still there when that one finishes, the sequencer holds,
//  and the input stays stalled, until it is taken.
// ----------------------------------------------------------------------------
module time_window_progress_grader_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input samples.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  twpg_pkg::t_twpg_in            i_in_item,
    // Results.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output twpg_pkg::t_twpg_out           o_out_item,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twpg_pkg::APB_AW-1:0]   paddr,
    input  logic [twpg_pkg::APB_DW-1:0]   pwdata,
    output logic [twpg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import twpg_pkg::*;

    // The sequencer. CHECK looks at the entry about to be overwritten and
    // writes the new sample, SCAN walks the ring, DONE updates the worst
    // window and FINISH grades it into the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE,
        ST_FINISH
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [TIME_W-1:0] r_horizon;
    logic [SUM_W-1:0]  r_comply;
    logic [SUM_W-1:0]  r_violate;

    // Item in work.
    logic [TIME_W-1:0] r_t_new;
    logic [CNTD_W-1:0] r_counted;
    logic              r_full_chk;

    // Run state.
    logic [FILL_W-1:0]  r_fill;
    logic [RING_AW-1:0] r_wslot;
    logic [SUM_W-1:0]   r_best_sum;
    logic [TIME_W-1:0]  r_best_start;
    logic [TIME_W-1:0]  r_best_end;
    logic [CNT_W-1:0]   r_best_cnt;
    logic               r_clip;

    // Walk control.
    logic [FILL_W-1:0]  r_k;
    logic               r_pend;

    logic               r_out_vld;
    t_twpg_out          r_out;

    logic               in_acc;
    logic               out_take;
    logic               cfg_wr;
    logic               scan_issue;
    logic               out_load;
    logic [CNTD_W-1:0]  n_counted;
    logic [RING_AW-1:0] raddr;
    logic [1:0]         n_grade;

    t_twpg_acc_ctl      acc_ctl;
    logic [TIME_W-1:0]  rd_time;
    logic [CNTD_W-1:0]  rd_counted;
    logic               acc_hit;
    logic [SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   acc_cnt;
    logic [TIME_W-1:0]  acc_start;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_vld && !i_out_stall;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;

    // Progress counts only in the oncoming lane outside intersections, and
    // negative progress counts as zero.
    assign n_counted = (i_in_item.in_oncoming && !i_in_item.at_intersection &&
                        !i_in_item.progress_mm[PROG_W-1])
                       ? i_in_item.progress_mm[CNTD_W-1:0] : '0;

    assign scan_issue = (r_state == ST_SCAN) && (r_k < r_fill);
    assign out_load   = (r_state == ST_FINISH) && (!r_out_vld || !i_out_stall);

    // On accept the read port fetches the slot about to be overwritten; a
    // first sample of a run starts from slot zero with an empty ring.
    always_comb begin
        if (r_state == ST_SCAN) begin
            raddr = r_k[RING_AW-1:0];
        end else if (i_in_item.first_of_run) begin
            raddr = '0;
        end else begin
            raddr = r_wslot;
        end
    end

    assign acc_ctl.clear  = (r_state == ST_CHECK);
    assign acc_ctl.acc_en = (r_state == ST_SCAN) && r_pend;

    // The grade follows the two limits as written, in this order.
    always_comb begin
        if (r_best_sum < r_comply) begin
            n_grade = GRADE_COMPLIANT;
        end else if (r_best_sum < r_violate) begin
            n_grade = GRADE_MINOR;
        end else begin
            n_grade = GRADE_MAJOR;
        end
    end

    twpg_ring u_ring (
        .i_clk      (i_clk),
        .i_we       (r_state == ST_CHECK),
        .i_waddr    (r_wslot),
        .i_wtime    (r_t_new),
        .i_wcounted (r_counted),
        .i_raddr    (raddr),
        .o_rtime    (rd_time),
        .o_rcounted (rd_counted)
    );

    twpg_accum u_accum (
        .i_clk     (i_clk),
        .i_ctl     (acc_ctl),
        .i_t_new   (r_t_new),
        .i_horizon (r_horizon),
        .i_t_old   (rd_time),
        .i_counted (rd_counted),
        .o_hit     (acc_hit),
        .o_sum     (acc_sum),
        .o_cnt     (acc_cnt),
        .o_start   (acc_start)
    );

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_HORIZON: prdata = r_horizon;
            REG_COMPLY:  prdata = {1'b0, r_comply};
            REG_VIOLATE: prdata = {1'b0, r_violate};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon <= HORIZON_RST;
            r_comply  <= COMPLY_RST;
            r_violate <= VIOLATE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HORIZON: r_horizon <= pwdata;
                REG_COMPLY:  r_comply  <= pwdata[SUM_W-1:0];
                REG_VIOLATE: r_violate <= pwdata[SUM_W-1:0];
                default:     ;
            endcase
        end
    end

    // Sequencer, run state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill       <= '0;
            r_wslot      <= '0;
            r_best_sum   <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_best_cnt   <= '0;
            r_clip       <= 1'b0;
            r_k          <= '0;
            r_pend       <= 1'b0;
            r_full_chk   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_t_new   <= i_in_item.sample_time_ms;
                        r_counted <= n_counted;
                        if (i_in_item.first_of_run) begin
                            r_fill       <= '0;
                            r_wslot      <= '0;
                            r_best_sum   <= '0;
                            r_best_start <= '0;
                            r_best_end   <= '0;
                            r_best_cnt   <= '0;
                            r_clip       <= 1'b0;
                            r_full_chk   <= 1'b0;
                        end else begin
                            r_full_chk <= (r_fill == FILL_W'(RING_DEPTH));
                        end
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    // The entry being overwritten was lost from the window
                    // if it still lies within the new sample's horizon.
                    if (r_full_chk && acc_hit) begin
                        r_clip <= 1'b1;
                    end
                    if (!r_full_chk) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_wslot <= (r_wslot == RING_AW'(RING_DEPTH - 1)) ? '0
                                                                     : r_wslot + 1'b1;
                    r_k     <= '0;
                    r_pend  <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_k    <= r_k + FILL_W'(scan_issue);
                    r_pend <= scan_issue;
                    if (!scan_issue && !r_pend) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (acc_sum > r_best_sum) begin
                        r_best_sum   <= acc_sum;
                        r_best_start <= acc_start;
                        r_best_end   <= r_t_new;
                        r_best_cnt   <= acc_cnt;
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_load) begin
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.max_sum_mm     <= r_best_sum;
            r_out.worst_start_ms <= r_best_start;
            r_out.worst_end_ms   <= r_best_end;
            r_out.worst_count    <= r_best_cnt;
            r_out.grade          <= n_grade;
            r_out.window_clipped <= r_clip;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("fill count exceeds ring depth");

    // The walk never reads past the filled part of the ring.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_k <= r_fill))
        else $error("ring walk index beyond fill count");

    // The worst window sum only grows within a run.
    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (r_best_sum >= $past(r_best_sum)))
        else $error("worst window sum decreased");

    // A result is never dropped: a pending result is held while loading waits.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_vld && i_out_stall) |=>
            (r_state == ST_FINISH && r_out_vld))
        else $error("result overwritten while stalled");

endmodule

// ===== dv/time_window_progress_grader_core_test.sv =====
// ----------------------------------------------------------------------------
// time_window_progress_grader_core_test
// Self-checking bench for the time-window progress grader. A tracker class
// keeps its own copy of the sample ring, the run maximum and the registers.
// It works out the graded result for every accepted sample, and every result
// the core hands out is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module time_window_progress_grader_core_test;

    import twpg_pkg::*;

    // ------------------------------------------------------------------------
    // Result tracker. It holds the same ring of recent samples as the core,
    // the worst window of the current run, and the three limits, and it keeps
    // the queue of graded results that the core still owes.
    // ------------------------------------------------------------------------
    class window_grade_tracker;
        logic [TIME_W-1:0]  time_ring [RING_DEPTH];
        logic [CNTD_W-1:0]  counted_ring [RING_DEPTH];
        int unsigned        fill;
        logic [RING_AW-1:0] slot;
        logic [SUM_W-1:0]   best_sum;
        logic [TIME_W-1:0]  best_start;
        logic [TIME_W-1:0]  best_end;
        logic [CNT_W-1:0]   best_count;
        logic               clip_seen;
        logic [TIME_W-1:0]  horizon;
        logic [SUM_W-1:0]   comply_limit;
        logic [SUM_W-1:0]   violate_limit;
        t_twpg_out          pending_grades [$];
        int                 mismatches;
        int                 samples_seen;
        int                 runs_seen;
        int                 clipped_results;
        int                 grades_seen [3];

        function new();
            horizon         = HORIZON_RST;
            comply_limit    = COMPLY_RST;
            violate_limit   = VIOLATE_RST;
            mismatches      = 0;
            samples_seen    = 0;
            runs_seen       = 0;
            clipped_results = 0;
            grades_seen     = '{0, 0, 0};
            clear_run();
        endfunction

        // Ring contents need no clearing: only the first fill entries are read.
        function void clear_run();
            fill       = 0;
            slot       = '0;
            best_sum   = '0;
            best_start = '0;
            best_end   = '0;
            best_count = '0;
            clip_seen  = 1'b0;
        endfunction

        function void set_register(logic [1:0] idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_HORIZON: horizon       = val;
                REG_COMPLY:  comply_limit  = val[SUM_W-1:0];
                REG_VIOLATE: violate_limit = val[SUM_W-1:0];
                default: ;
            endcase
        endfunction

        // A stored sample that is not older than the new one is always inside.
        function bit in_window(logic [TIME_W-1:0] t_new, logic [TIME_W-1:0] t_old);
            return (t_old >= t_new) || ((t_new - t_old) <= horizon);
        endfunction

        function void take_sample(t_twpg_in s);
            logic [CNTD_W-1:0] counted;
            logic [TIME_W-1:0] t_new;
            logic [TIME_W-1:0] start;
            logic [31:0]       sum;
            logic [CNT_W-1:0]  n;
            t_twpg_out         r;
            int                k;

            t_new = s.sample_time_ms;
            if (s.first_of_run) begin
                clear_run();
                runs_seen++;
            end

            // Only forward progress in the oncoming lane outside intersections counts.
            counted = '0;
            if (s.in_oncoming && !s.at_intersection && !s.progress_mm[PROG_W-1]) begin
                counted = s.progress_mm[CNTD_W-1:0];
            end

            // With the ring full the oldest entry is overwritten; losing one that
            // still lies in the window marks the run as clipped.
            if (fill == RING_DEPTH) begin
                if (in_window(t_new, time_ring[slot])) begin
                    clip_seen = 1'b1;
                end
            end else begin
                fill++;
            end
            time_ring[slot]    = t_new;
            counted_ring[slot] = counted;
            slot               = slot + 1'b1;

            sum   = '0;
            n     = '0;
            start = t_new;
            for (k = 0; k < fill; k++) begin
                if (in_window(t_new, time_ring[k])) begin
                    sum = sum + counted_ring[k];
                    if (sum > SUM_MAX) begin
                        sum = SUM_MAX;
                    end
                    if (n != CNT_MAX) begin
                        n++;
                    end
                    if (time_ring[k] < start) begin
                        start = time_ring[k];
                    end
                end
            end

            // Ties keep the earlier worst window.
            if (sum > best_sum) begin
                best_sum   = sum[SUM_W-1:0];
                best_start = start;
                best_end   = t_new;
                best_count = n;
            end

            r.max_sum_mm     = best_sum;
            r.worst_start_ms = best_start;
            r.worst_end_ms   = best_end;
            r.worst_count    = best_count;
            if (best_sum < comply_limit) begin
                r.grade = GRADE_COMPLIANT;
            end else if (best_sum < violate_limit) begin
                r.grade = GRADE_MINOR;
            end else begin
                r.grade = GRADE_MAJOR;
            end
            r.window_clipped = clip_seen;
            pending_grades = {pending_grades, r};
            samples_seen++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_grade(t_twpg_out got);
            t_twpg_out want;

            if (pending_grades.size() == 0) begin
                $error("result with no sample waiting for it");
                mismatches++;
                return;
            end
            want = pending_grades.pop_front();
            compare_field("max_sum_mm", want.max_sum_mm, got.max_sum_mm);
            compare_field("worst_start_ms", want.worst_start_ms, got.worst_start_ms);
            compare_field("worst_end_ms", want.worst_end_ms, got.worst_end_ms);
            compare_field("worst_count", want.worst_count, got.worst_count);
            compare_field("grade", want.grade, got.grade);
            compare_field("window_clipped", want.window_clipped, got.window_clipped);
            grades_seen[want.grade]++;
            if (want.window_clipped) begin
                clipped_results++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the core starts at a known value.
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_twpg_in            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_twpg_out           o_out_item;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Idling switches for both sides, and the request for one long hold-off
    // of the result channel.
    bit                  tx_idles    = 1'b1;
    bit                  rx_idles    = 1'b1;
    bit                  hold_req    = 1'b0;
    int                  sent_total  = 0;
    int                  settings_used = 0;

    window_grade_tracker tracker = new();

    time_window_progress_grader_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // The run ends here if the core stops making progress.
    initial begin
        #20_000_000;
        $display("time_window_progress_grader_core_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the clock edge, so the values seen
    // are the ones the core saw. A result always belongs to an earlier sample,
    // so it is checked before the sample of the same edge is taken in.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                tracker.check_grade(o_out_item);
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.take_sample(i_in_item);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Each pass makes one assignment to the stall and then
    // waits on the clock before the next pass. On request it holds off for a long
    // stretch, so that one result parks in the output register and the core
    // then stalls the sample channel while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else if (rx_idles && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Configuration access. A write goes through a setup and an access phase, and it
    // is followed by a read of the same register to see that it took.
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] field_mask;

        field_mask = (idx == REG_HORIZON) ? '1 : {1'b0, {SUM_W{1'b1}}};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, val);
        // Read back: psel stays high, a new setup cycle starts right away.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (((prdata ^ val) & field_mask) != '0) begin
            $error("register %0d read back: expected %0d, got %0d",
                   idx, val & field_mask, prdata & field_mask);
            tracker.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one sample and returns at the edge where the core takes it. The
    // task is always entered at a clock edge, so valid gets a single update
    // per edge: low for an idle burst, or high with the next sample.
    task automatic send_sample(t_twpg_in s);
        if (tx_idles && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= s;
        do @(posedge i_clk); while (o_in_stall);
        sent_total++;
        if (sent_total == 700) begin
            hold_req = 1'b1;
        end
    endtask

    function automatic t_twpg_in make_sample(bit first, logic [TIME_W-1:0] t, int prog,
                                             bit oncoming, bit crossing);
        t_twpg_in s;

        s.first_of_run    = first;
        s.sample_time_ms  = t;
        s.progress_mm     = prog[PROG_W-1:0];
        s.in_oncoming     = oncoming;
        s.at_intersection = crossing;
        return s;
    endfunction

    // Stops offering and waits until every sample sent so far has had its
    // result checked. It is entered at the edge where the last sample was
    // taken, so the tracker has seen that sample by the following edge.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_grades.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // One run of samples. It opens with a first-of-run flag, then mostly moves
    // forward in time, either densely (many samples per window, so the ring
    // fills and clips) or sparsely. A few samples step back, repeat the time,
    // jump far ahead, or start a new run unannounced.
    // ------------------------------------------------------------------------
    task automatic play_run(int len, bit may_idle);
        logic [TIME_W-1:0] t;
        int                step_max;
        int                pick;
        int                k;
        int                prog;

        t        = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20000);
        step_max = $urandom_range(0, 1) ? 40 : 600;
        tx_idles = may_idle && ($urandom_range(0, 3) != 0);
        rx_idles = may_idle && ($urandom_range(0, 3) != 0);
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 19);
            if (k > 0) begin
                if (pick == 0) begin
                    t = t - $urandom_range(0, 400);
                end else if (pick == 1) begin
                    t = t + $urandom();
                end else if (pick != 2) begin
                    t = t + $urandom_range(0, step_max);
                end
            end
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                prog = $urandom();
            end else if (pick == 1) begin
                prog = -$urandom_range(1, 5000);
            end else begin
                prog = $urandom_range(0, 800);
            end
            send_sample(make_sample((k == 0) || ($urandom_range(0, 63) == 0), t, prog,
                                    $urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0));
        end
    endtask

    // One register setting: the core is drained, all three registers are
    // written, and random runs follow until the sample budget is spent.
    task automatic run_setting(logic [TIME_W-1:0] horizon, logic [SUM_W-1:0] comply,
                               logic [SUM_W-1:0] violate, int budget, bit may_idle);
        int start_count;

        wait_drained();
        write_reg(REG_HORIZON, horizon);
        write_reg(REG_COMPLY, {1'b0, comply});
        write_reg(REG_VIOLATE, {1'b0, violate});
        settings_used++;
        start_count = sent_total;
        while (sent_total - start_count < budget) begin
            play_run(($urandom_range(0, 3) == 0) ? $urandom_range(65, 160)
                                                 : $urandom_range(1, 70), may_idle);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset limits (window 1000 ms, limits
        // 1000 and 3000). A zero sample keeps the worst window empty, equal
        // sums must not replace it, negative progress is clamped, samples at
        // an intersection or outside the oncoming lane do not count, earlier
        // and equal times count as in the window, and the window edge is
        // exact to the millisecond.
        send_sample(make_sample(1, 0, 0, 1, 0));
        send_sample(make_sample(0, 100, 500, 1, 0));
        send_sample(make_sample(0, 200, 500, 1, 0));
        send_sample(make_sample(0, 300, -5, 1, 0));
        send_sample(make_sample(0, 400, 8388607, 1, 1));
        send_sample(make_sample(0, 500, 8388607, 0, 0));
        send_sample(make_sample(0, 600, 700, 0, 1));
        send_sample(make_sample(0, 50, 2000, 1, 0));
        send_sample(make_sample(0, 1600, -8388608, 1, 0));
        send_sample(make_sample(0, 3000, 8388607, 1, 0));
        send_sample(make_sample(0, 3000, 8388607, 1, 0));
        send_sample(make_sample(1, 32'hFFFF_FFFF, 100, 1, 0));
        send_sample(make_sample(0, 0, 100, 1, 0));
        send_sample(make_sample(1, 32'h8000_0000, 1, 1, 0));
        send_sample(make_sample(0, 32'h8000_03E8, 1, 1, 0));
        send_sample(make_sample(0, 32'h8000_07D1, 1, 1, 0));
        send_sample(make_sample(0, 32'h8000_07D1, 0, 0, 1));

        // Random part. The settings cover a zero and an all-ones window, both
        // limits at their extremes, and limits given in reversed order. The
        // last setting runs with no idling on either side.
        run_setting(HORIZON_RST, COMPLY_RST, VIOLATE_RST, 400, 1'b1);
        run_setting('0, '0, SUM_MAX, 300, 1'b1);
        run_setting('1, SUM_MAX, '0, 300, 1'b1);
        run_setting(500, SUM_W'(20000), SUM_W'(5000), 300, 1'b1);
        run_setting($urandom_range(0, 5000), SUM_W'($urandom_range(0, 60000)),
                    SUM_W'($urandom_range(0, 60000)), 300, 1'b1);
        run_setting(2500, SUM_W'(5000), SUM_W'(40000), 400, 1'b0);

        wait_drained();
        // Nothing more may come out; give the core a full item's time to show
        // a stray result.
        repeat (80) @(posedge i_clk);

        if (tracker.pending_grades.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_grades.size());
            tracker.mismatches++;
        end
        $display("Covered %0d samples in %0d runs over %0d register settings.",
                 tracker.samples_seen, tracker.runs_seen, settings_used + 1);
        $display("Grades seen: %0d compliant, %0d minor, %0d major; %0d results clipped.",
                 tracker.grades_seen[GRADE_COMPLIANT], tracker.grades_seen[GRADE_MINOR],
                 tracker.grades_seen[GRADE_MAJOR], tracker.clipped_results);
        if (tracker.mismatches == 0) begin
            $display("time_window_progress_grader_core_test: PASS");
        end else begin
            $display("time_window_progress_grader_core_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== time_window_progress_grader_core.f =====
rtl/twpg_pkg.sv
rtl/twpg_ring.sv
rtl/twpg_accum.sv
rtl/time_window_progress_grader_core.sv
dv/time_window_progress_grader_core_test.sv
